FILE: sv/iring_pkg.sv
// ----------------------------------------------------------------------------
// iring_pkg
// Shared types, codes and helpers for the indexed ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package iring_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 16;
	localparam int CAP_W   = 7;
	localparam int CAP_MAX = 127;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_GET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OCCUPIED = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                command;
		logic [VALUE_W-1:0]  entry_value;
		logic [INDEX_W-1:0]  slot_index;
		logic                overwrite;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  value_out;
		logic                value_present;
		logic [CAP_W-1:0]    fill_level;
		logic                is_full;
		logic                is_empty;
	} rsp_t;

	// request to the shared remainder unit
	typedef struct packed {
		logic                go;
		logic [INDEX_W-1:0]  numer;
		logic [CAP_W-1:0]    divisor;
	} rem_req_t;

	typedef struct packed {
		logic                done;
		logic [CAP_W-1:0]    remainder;
	} rem_rsp_t;

	// clamp a raw capacity into 1..slots
	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] raw,
		input logic [CAP_W-1:0] slots);
		logic [CAP_W-1:0] res;
		if (raw == '0) begin
			res = {{(CAP_W-1){1'b0}}, 1'b1};
		end else if (raw > slots) begin
			res = slots;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: sv/iring_rem.sv
// ----------------------------------------------------------------------------
// iring_rem
// Restoring remainder unit: one numerator bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`default_nettype none

module iring_rem (
	input  wire                    clk,
	input  wire                    arst_n,
	input  iring_pkg::rem_req_t    req,
	output iring_pkg::rem_rsp_t    rsp
);

	localparam int CntW = $clog2(iring_pkg::INDEX_W + 1);

	logic [CntW-1:0]                 cnt_q;
	logic                            done_q;
	logic [iring_pkg::INDEX_W-1:0]   numer_q;
	logic [iring_pkg::CAP_W-1:0]     divisor_q;
	logic [iring_pkg::CAP_W-1:0]     rem_q;

	logic [iring_pkg::CAP_W:0]       trial;
	logic [iring_pkg::CAP_W:0]       diff;
	logic [iring_pkg::CAP_W-1:0]     rem_d;

	// shift in the next bit, subtract when it fits
	always_comb begin
		trial = {rem_q, numer_q[iring_pkg::INDEX_W-1]};
		diff  = trial - {1'b0, divisor_q};
		if (trial >= {1'b0, divisor_q}) begin
			rem_d = diff[iring_pkg::CAP_W-1:0];
		end else begin
			rem_d = trial[iring_pkg::CAP_W-1:0];
		end
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q <= CntW'(iring_pkg::INDEX_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (req.go) begin
			numer_q   <= req.numer;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (cnt_q != '0) begin
			numer_q <= {numer_q[iring_pkg::INDEX_W-2:0], 1'b0};
			rem_q   <= rem_d;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

FILE: sv/iring_slot_mem.sv
// ----------------------------------------------------------------------------
// iring_slot_mem
// Slot word store: one shared address, write port and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iring_slot_mem #(
	parameter int Depth = 64
) (
	input  wire                              clk,
	input  wire                              we,
	input  wire  [$clog2(Depth)-1:0]         addr,
	input  wire  [iring_pkg::VALUE_W-1:0]    wdata,
	output logic [iring_pkg::VALUE_W-1:0]    rdata
);

	logic [iring_pkg::VALUE_W-1:0] mem_q [Depth];
	logic [iring_pkg::VALUE_W-1:0] rdata_q;

	// write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/indexed_ring_queue.sv
// Push and pop go from idle through the access state to the reply state, where
// the done strobe is raised; insert and get first pass the reduce state, where
// the 16-step shared remainder unit reduces the slot index. New commands are
// taken only while idle. The first item after a capacity write also has both
// positions reduced by the same remainder unit. The receiver cannot stall.
// Reset clears positions, fill count and all occupied marks at once.
// ----------------------------------------------------------------------------
// indexed_ring_queue
// Circular queue with occupied marks, push/pop and indexed insert/get.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_ring_queue #(
	parameter int DEPTH = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  iring_pkg::req_t                   request,
	output logic                              done,
	output iring_pkg::rsp_t                   result,
	input  wire                               capacity_we,
	input  wire  [iring_pkg::CAP_W-1:0]       capacity_wdata
);

	localparam int SLOTS = (DEPTH < iring_pkg::CAP_MAX) ? DEPTH : iring_pkg::CAP_MAX;
	localparam int PW    = $clog2(SLOTS);
	localparam int CW    = iring_pkg::CAP_W;

	localparam logic [CW-1:0] SlotsCap = CW'(SLOTS);

	typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_ACCESS, S_REPLY} state_t;
	typedef enum logic [1:0] {J_WPOS, J_RPOS, J_INDEX} job_t;

	state_t                          state_q;
	job_t                            job_q;
	iring_pkg::req_t                 req_q;
	logic [PW-1:0]                   wpos_q;
	logic [PW-1:0]                   rpos_q;
	logic [PW-1:0]                   loc_q;
	logic [CW-1:0]                   fill_q;
	logic [CW-1:0]                   effcap_q;
	logic                            dirty_q;
	logic [SLOTS-1:0]                occ_q;
	iring_pkg::status_t              status_q;
	logic                            present_q;

	iring_pkg::rem_req_t             rem_req;
	iring_pkg::rem_rsp_t             rem_rsp;

	logic                            accept;
	logic                            indexed;
	logic [CW-1:0]                   new_cap;

	logic                            full_now;
	logic                            empty_now;
	logic [CW-1:0]                   wpos_inc;
	logic [CW-1:0]                   rpos_inc;
	logic [CW-1:0]                   fill_up;
	logic [CW-1:0]                   fill_down;

	iring_pkg::status_t              acc_status;
	logic                            acc_we;
	logic [PW-1:0]                   acc_addr;
	logic                            acc_present;
	logic                            acc_occ_set;
	logic                            acc_occ_clr;
	logic [PW-1:0]                   wpos_d;
	logic [PW-1:0]                   rpos_d;
	logic [CW-1:0]                   fill_d;

	logic [iring_pkg::VALUE_W-1:0]   mem_rdata;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && (state_q == S_IDLE);
	assign indexed = (request.command == iring_pkg::CMD_INSERT) ||
		(request.command == iring_pkg::CMD_GET);
	assign new_cap = iring_pkg::eff_cap(capacity_wdata, SlotsCap);

	// launch the shared remainder unit
	always_comb begin
		rem_req.go      = 1'b0;
		rem_req.numer   = iring_pkg::INDEX_W'(wpos_q);
		rem_req.divisor = effcap_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (dirty_q) begin
						rem_req.go = 1'b1;
					end else if (indexed) begin
						rem_req.go    = 1'b1;
						rem_req.numer = request.slot_index;
					end
				end
			end
			S_REDUCE: begin
				if (rem_rsp.done) begin
					if (job_q == J_WPOS) begin
						rem_req.go    = 1'b1;
						rem_req.numer = iring_pkg::INDEX_W'(rpos_q);
					end else if (job_q == J_RPOS &&
						(req_q.command == iring_pkg::CMD_INSERT ||
						req_q.command == iring_pkg::CMD_GET)) begin
						rem_req.go    = 1'b1;
						rem_req.numer = req_q.slot_index;
					end
				end
			end
			default: begin
			end
		endcase
	end

	iring_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// queue flags and wrapped position steps
	always_comb begin
		full_now  = (wpos_q == rpos_q) && (fill_q != '0);
		empty_now = (wpos_q == rpos_q) && (fill_q == '0);
		wpos_inc  = CW'(wpos_q) + 1'b1;
		rpos_inc  = CW'(rpos_q) + 1'b1;
		if (wpos_inc == effcap_q) begin
			wpos_inc = '0;
		end
		if (rpos_inc == effcap_q) begin
			rpos_inc = '0;
		end
		fill_up   = (fill_q < effcap_q) ? fill_q + 1'b1 : fill_q;
		fill_down = (fill_q != '0) ? fill_q - 1'b1 : fill_q;
	end

	// decide the slot access for the held command
	always_comb begin
		acc_status  = iring_pkg::ST_OK;
		acc_we      = 1'b0;
		acc_addr    = loc_q;
		acc_present = 1'b0;
		acc_occ_set = 1'b0;
		acc_occ_clr = 1'b0;
		wpos_d      = wpos_q;
		rpos_d      = rpos_q;
		fill_d      = fill_q;
		case (req_q.command)
			iring_pkg::CMD_PUSH: begin
				acc_addr = wpos_q;
				if (full_now) begin
					acc_status = iring_pkg::ST_FULL;
				end else begin
					acc_we      = 1'b1;
					acc_occ_set = 1'b1;
					wpos_d      = PW'(wpos_inc);
					fill_d      = fill_up;
				end
			end
			iring_pkg::CMD_POP: begin
				acc_addr = rpos_q;
				if (empty_now) begin
					acc_status = iring_pkg::ST_EMPTY;
				end else begin
					acc_present = occ_q[rpos_q];
					acc_occ_clr = 1'b1;
					rpos_d      = PW'(rpos_inc);
					fill_d      = fill_down;
				end
			end
			iring_pkg::CMD_INSERT: begin
				if (occ_q[loc_q]) begin
					if (req_q.overwrite) begin
						acc_we = 1'b1;
					end else begin
						acc_status = iring_pkg::ST_OCCUPIED;
					end
				end else begin
					acc_we      = 1'b1;
					acc_occ_set = 1'b1;
					fill_d      = fill_up;
				end
			end
			iring_pkg::CMD_GET: begin
				acc_present = occ_q[loc_q];
			end
			default: begin
			end
		endcase
	end

	iring_slot_mem #(
		.Depth (SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (acc_we && (state_q == S_ACCESS)),
		.addr  (acc_addr),
		.wdata (req_q.entry_value),
		.rdata (mem_rdata)
	);

	// sequencer, queue state and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= J_WPOS;
			req_q     <= '0;
			wpos_q    <= '0;
			rpos_q    <= '0;
			loc_q     <= '0;
			fill_q    <= '0;
			effcap_q  <= iring_pkg::eff_cap(iring_pkg::CAP_RESET, SlotsCap);
			dirty_q   <= 1'b0;
			occ_q     <= '0;
			status_q  <= iring_pkg::ST_OK;
			present_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (capacity_we) begin
						effcap_q <= new_cap;
						dirty_q  <= 1'b1;
						if (fill_q > new_cap) begin
							fill_q <= new_cap;
						end
					end
					if (accept) begin
						// hold the item for the whole command
						req_q <= request;
						if (dirty_q) begin
							job_q   <= J_WPOS;
							state_q <= S_REDUCE;
						end else if (indexed) begin
							job_q   <= J_INDEX;
							state_q <= S_REDUCE;
						end else begin
							state_q <= S_ACCESS;
						end
					end
				end
				S_REDUCE: begin
					if (rem_rsp.done) begin
						case (job_q)
							J_WPOS: begin
								wpos_q <= PW'(rem_rsp.remainder);
								job_q  <= J_RPOS;
							end
							J_RPOS: begin
								rpos_q  <= PW'(rem_rsp.remainder);
								dirty_q <= 1'b0;
								if (rem_req.go) begin
									job_q <= J_INDEX;
								end else begin
									state_q <= S_ACCESS;
								end
							end
							default: begin
								loc_q   <= PW'(rem_rsp.remainder);
								state_q <= S_ACCESS;
							end
						endcase
					end
				end
				S_ACCESS: begin
					status_q  <= acc_status;
					present_q <= acc_present;
					wpos_q    <= wpos_d;
					rpos_q    <= rpos_d;
					fill_q    <= fill_d;
					if (acc_occ_set) begin
						occ_q[acc_addr] <= 1'b1;
					end
					if (acc_occ_clr) begin
						occ_q[acc_addr] <= 1'b0;
					end
					state_q <= S_REPLY;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// present the item for one cycle
	always_comb begin
		done                 = (state_q == S_REPLY);
		result.status        = status_q;
		result.value_out     = present_q ? mem_rdata : '0;
		result.value_present = present_q;
		result.fill_level    = fill_q;
		result.is_full       = full_now;
		result.is_empty      = empty_now;
	end

endmodule

`default_nettype wire

FILE: tb/sv/indexed_ring_queue_tb.sv
// ----------------------------------------------------------------------------
// indexed_ring_queue_tb
// Self-checking bench for the indexed ring queue. An item-level model of the
// slots, positions and fill count predicts every result; a monitor compares
// each done strobe against the oldest prediction. Directed items cover the
// refusals, overwrite, unoccupied reads and capacity clamping, then random
// traffic runs over several capacities with random sender gaps.
// ----------------------------------------------------------------------------
module indexed_ring_queue_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import iring_pkg::*;

	localparam int          SLOTS         = 64;
	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int          SETTLE_CYCLES = 60;
	localparam int          PRINT_LIMIT   = 100;

	typedef enum int {
		MIX_BALANCED,
		MIX_FILLING,
		MIX_DRAINING
	} traffic_mix_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic               busy;
	req_t               request        = '0;
	logic               done;
	rsp_t               result;
	logic               capacity_we    = 1'b0;
	logic [CAP_W-1:0]   capacity_wdata = '0;

	// queue model state
	logic [VALUE_W-1:0] slot_word    [SLOTS];
	bit                 slot_taken   [SLOTS];
	bit                 slot_written [SLOTS];
	int unsigned        wr_pos   = 0;
	int unsigned        rd_pos   = 0;
	int unsigned        fill_cnt = 0;
	logic [CAP_W-1:0]   cap_raw  = CAP_RESET;

	rsp_t               expected_responses [$];
	rsp_t               oldest;
	int unsigned        error_count = 0;
	int unsigned        cycle_count = 0;
	bit                 gaps_on     = 1'b1;

	indexed_ring_queue #(
		.DEPTH(SLOTS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.done          (done),
		.result        (result),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	// compare each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				report_error("result strobe with no item outstanding");
			end else begin
				oldest = expected_responses.pop_front();
				check_field("status", result.status, oldest.status);
				check_field("value_out", result.value_out, oldest.value_out);
				check_field("value_present", result.value_present, oldest.value_present);
				check_field("fill_level", result.fill_level, oldest.fill_level);
				check_field("is_full", result.is_full, oldest.is_full);
				check_field("is_empty", result.is_empty, oldest.is_empty);
			end
		end
	end

	function automatic int unsigned active_cap();
		if (cap_raw == '0) return 1;
		if (cap_raw > SLOTS) return SLOTS;
		return cap_raw;
	endfunction

	// advance the queue model by one item and return its result
	function automatic rsp_t predict_response(input req_t item);
		rsp_t        r;
		int unsigned cap;
		int unsigned loc;
		cap    = active_cap();
		wr_pos = wr_pos % cap;
		rd_pos = rd_pos % cap;
		loc    = int'(item.slot_index) % cap;
		r      = '0;
		r.status = ST_OK;
		case (item.command)
			CMD_PUSH: begin
				if (wr_pos == rd_pos && fill_cnt != 0) begin
					r.status = ST_FULL;
				end else begin
					slot_word[wr_pos]    = item.entry_value;
					slot_taken[wr_pos]   = 1'b1;
					slot_written[wr_pos] = 1'b1;
					wr_pos = (wr_pos + 1) % cap;
					if (fill_cnt < cap) fill_cnt++;
				end
			end
			CMD_POP: begin
				if (wr_pos == rd_pos && fill_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value_present = slot_taken[rd_pos];
					r.value_out     = slot_taken[rd_pos] ? slot_word[rd_pos] : '0;
					slot_taken[rd_pos] = 1'b0;
					rd_pos = (rd_pos + 1) % cap;
					if (fill_cnt > 0) fill_cnt--;
				end
			end
			CMD_INSERT: begin
				if (slot_taken[loc]) begin
					if (item.overwrite) begin
						slot_word[loc] = item.entry_value;
					end else begin
						r.status = ST_OCCUPIED;
					end
				end else begin
					slot_word[loc]    = item.entry_value;
					slot_taken[loc]   = 1'b1;
					slot_written[loc] = 1'b1;
					if (fill_cnt < cap) fill_cnt++;
				end
			end
			default: begin
				r.value_present = slot_taken[loc];
				r.value_out     = slot_taken[loc] ? slot_word[loc] : '0;
			end
		endcase
		r.fill_level = CAP_W'(fill_cnt);
		r.is_full    = (wr_pos == rd_pos) && (fill_cnt != 0);
		r.is_empty   = (wr_pos == rd_pos) && (fill_cnt == 0);
		return r;
	endfunction

	// turn a read of a never-written slot into a push
	function automatic req_t steer_off_unwritten(input req_t item);
		int unsigned cap;
		int unsigned rd;
		int unsigned wr;
		req_t        safe;
		cap  = active_cap();
		rd   = rd_pos % cap;
		wr   = wr_pos % cap;
		safe = item;
		if (item.command == CMD_POP && !(wr == rd && fill_cnt == 0)
				&& !slot_written[rd]) begin
			safe.command = CMD_PUSH;
		end else if (item.command == CMD_GET
				&& !slot_written[int'(item.slot_index) % cap]) begin
			safe.command = CMD_PUSH;
		end
		return safe;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t compose_item(input cmd_t cmd, input logic [VALUE_W-1:0] value,
		input logic [INDEX_W-1:0] index, input logic ovw);
		req_t item;
		item.command     = cmd;
		item.entry_value = value;
		item.slot_index  = index;
		item.overwrite   = ovw;
		return item;
	endfunction

	function automatic req_t random_item(input traffic_mix_t mix);
		req_t        item;
		int unsigned roll;
		int unsigned push_top;
		int unsigned pop_top;
		int unsigned insert_top;
		int unsigned cap;
		cap = active_cap();
		case (mix)
			MIX_FILLING: begin
				push_top = 55; pop_top = 65; insert_top = 85;
			end
			MIX_DRAINING: begin
				push_top = 10; pop_top = 70; insert_top = 80;
			end
			default: begin
				push_top = 30; pop_top = 60; insert_top = 80;
			end
		endcase
		roll = $urandom_range(0, 99);
		item.command = (roll < push_top) ? CMD_PUSH :
			(roll < pop_top) ? CMD_POP :
			(roll < insert_top) ? CMD_INSERT : CMD_GET;
		roll = $urandom_range(0, 15);
		item.entry_value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
		roll = $urandom_range(0, 9);
		item.slot_index = (roll == 0) ? '1 : (roll == 1) ? '0 :
			(roll < 4) ? INDEX_W'($urandom_range(0, 65535)) :
			INDEX_W'($urandom_range(0, 2 * cap - 1));
		item.overwrite = 1'($urandom_range(0, 1));
		return item;
	endfunction

	// hold start until the block takes the item, then idle at random
	task automatic send_item(input req_t item);
		req_t        safe;
		int unsigned gap;
		safe = steer_off_unwritten(item);
		request <= safe;
		if (!start) start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_responses.push_back(predict_response(safe));
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (start) start <= 1'b0;
		while (expected_responses.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		int unsigned cap;
		wait_drained();
		capacity_we    <= 1'b1;
		capacity_wdata <= value;
		@(posedge clk);
		capacity_we <= 1'b0;
		// reduce positions and clamp the fill count
		cap_raw = value;
		cap     = active_cap();
		wr_pos  = wr_pos % cap;
		rd_pos  = rd_pos % cap;
		if (fill_cnt > cap) fill_cnt = cap;
	endtask

	task automatic run_traffic(input int unsigned count);
		traffic_mix_t mix;
		mix = MIX_FILLING;
		repeat (count) begin
			if ($urandom_range(0, 11) == 0) begin
				mix = traffic_mix_t'($urandom_range(0, 2));
			end
			send_item(random_item(mix));
		end
	endtask

	// push/pop ordering, full and empty refusals at capacity 2
	task automatic test_queue_order();
		set_capacity(7'd2);
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
		send_item(compose_item(CMD_PUSH, '1, '0, 1'b0));
		send_item(compose_item(CMD_PUSH, '0, '1, 1'b1));
		send_item(compose_item(CMD_PUSH, 32'h1111_1111, '0, 1'b0));
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
	endtask

	// insert refusal and overwrite, reads of unoccupied slots, push over a mark
	task automatic test_indexed_slots();
		send_item(compose_item(CMD_INSERT, 32'hA5A5_A5A5, '1, 1'b0));
		send_item(compose_item(CMD_INSERT, 32'h5A5A_5A5A, 16'd1, 1'b0));
		send_item(compose_item(CMD_INSERT, 32'h1234_5678, 16'd1, 1'b1));
		send_item(compose_item(CMD_GET, '0, '1, 1'b0));
		send_item(compose_item(CMD_GET, '0, '0, 1'b0));
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
		send_item(compose_item(CMD_PUSH, 32'hDEAD_BEEF, '0, 1'b0));
		send_item(compose_item(CMD_PUSH, 32'h7777_7777, '0, 1'b0));
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
		send_item(compose_item(CMD_INSERT, 32'h0BAD_F00D, 16'd1, 1'b0));
		send_item(compose_item(CMD_PUSH, 32'hCAFE_F00D, '0, 1'b0));
		send_item(compose_item(CMD_INSERT, 32'h4444_4444, 16'd2, 1'b0));
	endtask

	// shrink with fill saturation, zero acts as one, oversize clamps
	task automatic test_capacity_limits();
		set_capacity(7'd1);
		send_item(compose_item(CMD_GET, '0, '1, 1'b0));
		send_item(compose_item(CMD_POP, '0, '0, 1'b0));
		send_item(compose_item(CMD_PUSH, 32'h0F0F_0F0F, '0, 1'b0));
		set_capacity(7'd0);
		send_item(compose_item(CMD_PUSH, 32'hF0F0_F0F0, '0, 1'b0));
		send_item(compose_item(CMD_GET, '0, 16'h8000, 1'b0));
		set_capacity(7'd127);
		send_item(compose_item(CMD_INSERT, 32'h8000_0001, '1, 1'b0));
		send_item(compose_item(CMD_GET, '0, '1, 1'b0));
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [10] = '{7'd64, 7'd3, 7'd1, 7'd127, 7'd17,
			7'd0, 7'd64, 7'd5, 7'd40, 7'd2};
		for (int p = 0; p < 10; p++) begin
			set_capacity(caps[p]);
			// one phase runs back to back with no sender gaps
			gaps_on = (p != 1);
			run_traffic(70);
		end
		gaps_on = 1'b1;
	endtask

	// let every result come back in the middle of a stream
	task automatic test_pause_for_drain();
		set_capacity(7'd64);
		run_traffic(15);
		wait_drained();
		run_traffic(15);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_word[i]    = '0;
			slot_taken[i]   = 1'b0;
			slot_written[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_queue_order();
		test_indexed_slots();
		test_capacity_limits();
		test_random_traffic();
		test_pause_for_drain();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
